// ===== rtl/hdg_pkg.sv =====
// Shared types, constants and tables for the compass and gyro heading unit.
package hdg_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

   localparam int FIELD_W   = 16;
   localparam int FIXED_W   = 17;
   localparam int DECL_W    = 17;
   localparam int TICK_W    = 10;
   localparam int STEPPROD_W = FIXED_W + TICK_W + 1;
   localparam int VEC_W     = 36;
   localparam int ANG_W     = 26;
   localparam int ROUND_W   = ANG_W - 8;
   localparam int DIFF_W    = 19;
   localparam int HEAD_W    = 17;
   localparam int ACC_W     = 48;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 152;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic signed [ANG_W-1:0]  DEG180_Q16 = 26'sd11796480;
   localparam logic signed [ROUND_W-1:0] HALF_TURN = 18'sd46080;
   localparam logic signed [DIFF_W-1:0] FULL_TURN  = 19'sd92160;
   localparam logic signed [ACC_W-1:0]  ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic [21:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
      22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
      22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAG_X_OFFSET  = 3'd0,
      CSR_MAG_Y_OFFSET  = 3'd1,
      CSR_GYRO_X_OFFSET = 3'd2,
      CSR_GYRO_Y_OFFSET = 3'd3,
      CSR_GYRO_Z_OFFSET = 3'd4,
      CSR_DECLINATION   = 3'd5,
      CSR_TICK_PERIOD   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] mag_x_offset;
      logic signed [FIELD_W-1:0] mag_y_offset;
      logic signed [FIELD_W-1:0] gyro_x_offset;
      logic signed [FIELD_W-1:0] gyro_y_offset;
      logic signed [FIELD_W-1:0] gyro_z_offset;
      logic signed [DECL_W-1:0]  declination;
      logic [TICK_W-1:0]         tick_period_ms;
   } hdg_cfg_type;

   typedef struct packed {
      logic signed [FIXED_W-1:0]    gyro_x_fixed;
      logic signed [FIXED_W-1:0]    gyro_y_fixed;
      logic signed [FIXED_W-1:0]    gyro_z_fixed;
      logic signed [FIXED_W-1:0]    mag_x_fixed;
      logic signed [FIXED_W-1:0]    mag_y_fixed;
      logic signed [STEPPROD_W-1:0] gyro_step;
      logic                         mag_x_zero;
      logic                         mag_y_pos;
   } hdg_side_type;

   typedef struct packed {
      logic                     valid;
      logic signed [VEC_W-1:0]  x;
      logic signed [VEC_W-1:0]  y;
      logic signed [ANG_W-1:0]  z;
      hdg_side_type             side;
   } hdg_cell_type;

endpackage

// ===== rtl/compass_and_gyro_heading_unit.sv =====
// Top level of the compass and gyro heading unit: registers, cell chain and output.
//
// Takes one sample word per cycle and returns one result word per sample, in order.
// The pipeline is one input stage, CORDIC_STEPS (16) CORDIC cells and two output stages;
// throughput is one word per cycle when not stalled, set by the unrolled row of CORDIC
// cells and by the gyro accumulator, whose feedback loop closes through acc_ff. The
// whole pipeline advances together and holds while rsp_tvalid is high and
// rsp_tready is low. Register writes are taken at any time. Offsets and tick period
// act on samples accepted afterwards, but declination is applied in the output
// stage to samples already in flight; change registers only while the unit is empty.
module compass_and_gyro_heading_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] mag_x_raw, [31:16] mag_y_raw, [47:32] gyro_x_raw,
   // [63:48] gyro_y_raw, [79:64] gyro_z_raw
   input  logic [hdg_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [16:0] gyro_x_fixed, [33:17] gyro_y_fixed, [50:34] gyro_z_fixed,
   // [67:51] mag_x_fixed, [84:68] mag_y_fixed, [101:85] compass_heading,
   // [149:102] gyro_heading, [151:150] zero
   output logic [hdg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hdg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hdg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import hdg_pkg::*;

   hdg_cfg_type  cfg_ff;
   hdg_cell_type chain [CORDIC_STEPS+1];
   logic         adv;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mag_x_offset   <= 16'sd320;
         cfg_ff.mag_y_offset   <= -16'sd38;
         cfg_ff.gyro_x_offset  <= -16'sd10;
         cfg_ff.gyro_y_offset  <= -16'sd22;
         cfg_ff.gyro_z_offset  <= -16'sd11;
         cfg_ff.declination    <= -17'sd2048;
         cfg_ff.tick_period_ms <= 10'd200;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAG_X_OFFSET:  cfg_ff.mag_x_offset   <= csr_data[15:0];
            CSR_MAG_Y_OFFSET:  cfg_ff.mag_y_offset   <= csr_data[15:0];
            CSR_GYRO_X_OFFSET: cfg_ff.gyro_x_offset  <= csr_data[15:0];
            CSR_GYRO_Y_OFFSET: cfg_ff.gyro_y_offset  <= csr_data[15:0];
            CSR_GYRO_Z_OFFSET: cfg_ff.gyro_z_offset  <= csr_data[15:0];
            CSR_DECLINATION:   cfg_ff.declination    <= csr_data;
            CSR_TICK_PERIOD:   cfg_ff.tick_period_ms <= csr_data[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   hdg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .stage_ff   (chain[0])
   );

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      hdg_cordic_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .step_index (STEP_W'(g)),
         .cell_in    (chain[g]),
         .cell_ff    (chain[g+1])
      );
   end

   hdg_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .cell_in      (chain[CORDIC_STEPS]),
      .declination  (cfg_ff.declination),
      .rsp_valid_ff (rsp_tvalid),
      .rsp_data_ff  (rsp_tdata)
   );

endmodule

// ===== rtl/hdg_front.sv =====
// Input stage: bias removal, gyro step product and CORDIC pre-rotation.
module hdg_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         req_tvalid,
   input  logic [hdg_pkg::REQ_DATA_W-1:0] req_tdata,
   input  hdg_pkg::hdg_cfg_type          cfg,
   output hdg_pkg::hdg_cell_type         stage_ff
);
   import hdg_pkg::*;

   logic signed [FIELD_W-1:0]    mag_x_raw, mag_y_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw;
   logic signed [FIXED_W-1:0]    mx, my, gx, gy, gz;
   logic signed [STEPPROD_W-1:0] step;
   logic signed [VEC_W-1:0]      x0, y0;
   hdg_cell_type                 stage_in;

   always_comb begin
      mag_x_raw  = req_tdata[15:0];
      mag_y_raw  = req_tdata[31:16];
      gyro_x_raw = req_tdata[47:32];
      gyro_y_raw = req_tdata[63:48];
      gyro_z_raw = req_tdata[79:64];

      mx = {mag_x_raw[15], mag_x_raw} - {cfg.mag_x_offset[15], cfg.mag_x_offset};
      my = {cfg.mag_y_offset[15], cfg.mag_y_offset} - {mag_y_raw[15], mag_y_raw};
      gx = {gyro_x_raw[15], gyro_x_raw} - {cfg.gyro_x_offset[15], cfg.gyro_x_offset};
      gy = {gyro_y_raw[15], gyro_y_raw} - {cfg.gyro_y_offset[15], cfg.gyro_y_offset};
      gz = {gyro_z_raw[15], gyro_z_raw} - {cfg.gyro_z_offset[15], cfg.gyro_z_offset};

      step = STEPPROD_W'(gz) * $signed({1'b0, cfg.tick_period_ms});

      x0 = {{(VEC_W-FIXED_W-16){my[FIXED_W-1]}}, my, 16'b0};
      y0 = {{(VEC_W-FIXED_W-16){mx[FIXED_W-1]}}, mx, 16'b0};

      stage_in.valid = req_tvalid;
      if (my < 0) begin
         stage_in.x = -x0;
         stage_in.y = -y0;
         stage_in.z = (mx >= 0) ? DEG180_Q16 : -DEG180_Q16;
      end else begin
         stage_in.x = x0;
         stage_in.y = y0;
         stage_in.z = '0;
      end

      stage_in.side.gyro_x_fixed = gx;
      stage_in.side.gyro_y_fixed = gy;
      stage_in.side.gyro_z_fixed = gz;
      stage_in.side.mag_x_fixed  = mx;
      stage_in.side.mag_y_fixed  = my;
      stage_in.side.gyro_step    = step;
      stage_in.side.mag_x_zero   = (mx == '0);
      stage_in.side.mag_y_pos    = (my > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// ===== rtl/hdg_cordic_cell.sv =====
// One CORDIC vectoring cell: a single micro-rotation, registered.
module hdg_cordic_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic [hdg_pkg::STEP_W-1:0]   step_index,
   input  hdg_pkg::hdg_cell_type         cell_in,
   output hdg_pkg::hdg_cell_type         cell_ff
);
   import hdg_pkg::*;

   logic signed [VEC_W-1:0] x_cur, y_cur, xs, ys;
   logic signed [ANG_W-1:0] z_cur, atan_step;
   hdg_cell_type            cell_next;

   always_comb begin
      x_cur     = cell_in.x;
      y_cur     = cell_in.y;
      z_cur     = cell_in.z;
      xs        = x_cur >>> step_index;
      ys        = y_cur >>> step_index;
      atan_step = $signed({{(ANG_W-22){1'b0}}, ATAN_TABLE[ATAN_IDX_W'(step_index)]});
      cell_next = cell_in;
      if (y_cur >= 0) begin
         cell_next.x = x_cur + ys;
         cell_next.y = y_cur - xs;
         cell_next.z = z_cur + atan_step;
      end else begin
         cell_next.x = x_cur - ys;
         cell_next.y = y_cur + xs;
         cell_next.z = z_cur - atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_next;
      end
   end

endmodule

// ===== rtl/hdg_finish.sv =====
// Output stages: angle rounding, declination, wrap, gyro accumulator, result register.
module hdg_finish (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  hdg_pkg::hdg_cell_type             cell_in,
   input  logic signed [hdg_pkg::DECL_W-1:0] declination,
   output logic                             rsp_valid_ff,
   output logic [hdg_pkg::RSP_DATA_W-1:0]    rsp_data_ff
);
   import hdg_pkg::*;

   typedef struct packed {
      logic                     valid;
      logic signed [DIFF_W-1:0] diff;
      hdg_side_type             side;
   } hdg_angle_type;

   hdg_angle_type              angle_ff, angle_in;
   logic signed [ANG_W-1:0]    z_round;
   logic signed [ROUND_W-1:0]  ang;
   logic signed [DIFF_W-1:0]   wrapped;
   logic signed [ACC_W:0]      acc_sum;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [RSP_DATA_W-1:0]      rsp_data_in;

   always_comb begin
      z_round = cell_in.z + ANG_W'(128);
      if (cell_in.side.mag_x_zero) begin
         ang = cell_in.side.mag_y_pos ? HALF_TURN : '0;
      end else begin
         ang = z_round[ANG_W-1:8];
      end
      angle_in.valid = cell_in.valid;
      angle_in.side  = cell_in.side;
      angle_in.diff  = DIFF_W'(ang) - DIFF_W'(declination);
   end

   always_comb begin
      if (angle_ff.diff >= FULL_TURN) begin
         wrapped = angle_ff.diff - FULL_TURN;
      end else if (angle_ff.diff >= -FULL_TURN && angle_ff.diff < 0) begin
         wrapped = angle_ff.diff + FULL_TURN;
      end else if (angle_ff.diff < -FULL_TURN) begin
         wrapped = angle_ff.diff + FULL_TURN + FULL_TURN;
      end else begin
         wrapped = angle_ff.diff;
      end

      acc_sum = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(angle_ff.side.gyro_step);
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_in = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = acc_sum[ACC_W-1:0];
      end

      rsp_data_in = {2'b00, acc_in, wrapped[HEAD_W-1:0],
                     angle_ff.side.mag_y_fixed, angle_ff.side.mag_x_fixed,
                     angle_ff.side.gyro_z_fixed, angle_ff.side.gyro_y_fixed,
                     angle_ff.side.gyro_x_fixed};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         acc_ff         <= '0;
      end else if (adv) begin
         angle_ff     <= angle_in;
         rsp_valid_ff <= angle_ff.valid;
         if (angle_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && angle_ff.valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
